[rtl/dbt_pkg.sv]
// Shared types, constants and table builders for the distance beep tone generator.
// Depends on nothing; imported by every module of the block.
package dbt_pkg;

	// Sample rate in ticks per second and sine table length (one entry per phase step)
	localparam int unsigned RATE_HZ         = 1000;
	localparam int unsigned TABLE_LEN       = 1000;
	localparam int unsigned PHASE_W         = $clog2(RATE_HZ);
	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam int unsigned XQ_DEPTH        = 2;
	localparam int unsigned GAP_W           = 10;
	localparam int unsigned REP_W           = 2;
	localparam int unsigned CODE_W          = 3;

	// Command codes on the request channel
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_EVENT = 2'd1;
	localparam logic [1:0] CMD_TONE  = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// Pattern codes
	localparam logic [CODE_W-1:0] PAT_NONE       = 3'd0;
	localparam logic [CODE_W-1:0] PAT_VERY_CLOSE = 3'd1;
	localparam logic [CODE_W-1:0] PAT_MID_CLOSE  = 3'd2;
	localparam logic [CODE_W-1:0] PAT_FAR        = 3'd3;
	localparam logic [CODE_W-1:0] PAT_VERY_FAR   = 3'd4;

	// Fixed-point sine constants
	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        very_close;
		logic        mid_close;
		logic        far_flag;
		logic        very_far;
		logic [15:0] tone_freq;
		logic [15:0] tone_ms;
	} req_t;

	typedef struct packed {
		logic [7:0] dac_value;
		logic       accepted;
		logic       playing;
	} rsp_t;

	// Tone as held in the tone queue: phase increment and sample count
	typedef struct packed {
		logic [PHASE_W-1:0] ps;
		logic [15:0]        ms;
	} tone_t;

	// Classified item passed from the front to the back
	typedef struct packed {
		logic [1:0]        kind;
		logic [CODE_W-1:0] code;
		tone_t             tone;
	} item_t;

	typedef logic [7:0] sine_rom_t [TABLE_LEN];

	function automatic logic [PHASE_W-1:0] pat_freq(input logic [CODE_W-1:0] code);
		logic [PHASE_W-1:0] f;
		unique case (code)
			PAT_VERY_CLOSE: f = PHASE_W'(880);
			PAT_MID_CLOSE:  f = PHASE_W'(660);
			PAT_FAR:        f = PHASE_W'(523);
			PAT_VERY_FAR:   f = PHASE_W'(440);
			default:        f = '0;
		endcase
		return f;
	endfunction

	function automatic logic [15:0] pat_ms(input logic [CODE_W-1:0] code);
		logic [15:0] m;
		unique case (code)
			PAT_VERY_CLOSE: m = 16'd100;
			PAT_MID_CLOSE:  m = 16'd150;
			PAT_FAR:        m = 16'd200;
			PAT_VERY_FAR:   m = 16'd100;
			default:        m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [GAP_W-1:0] pat_gap(input logic [CODE_W-1:0] code);
		logic [GAP_W-1:0] g;
		unique case (code)
			PAT_VERY_CLOSE: g = GAP_W'(150);
			PAT_MID_CLOSE:  g = GAP_W'(300);
			PAT_FAR:        g = GAP_W'(600);
			PAT_VERY_FAR:   g = GAP_W'(800);
			default:        g = '0;
		endcase
		return g;
	endfunction

	function automatic logic [REP_W-1:0] pat_reps(input logic [CODE_W-1:0] code);
		logic [REP_W-1:0] r;
		unique case (code)
			PAT_VERY_CLOSE: r = 2'd3;
			PAT_MID_CLOSE:  r = 2'd2;
			PAT_FAR:        r = 2'd1;
			PAT_VERY_FAR:   r = 2'd1;
			default:        r = 2'd0;
		endcase
		return r;
	endfunction

	// One sine entry: Q30 angle, fold to a quarter wave, Taylor series to x^17
	function automatic logic [7:0] sine_entry(input int unsigned p);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned u;
		longint          sum;
		logic            neg;
		x   = ((64'd628318 * 64'(p)) << 30) / 64'd100000000;
		neg = 1'b0;
		if (x >= PI_Q30) begin
			neg = 1'b1;
			x   = x - PI_Q30;
		end
		if (x > PI_Q30 / 2) x = PI_Q30 - x;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
		if (sum < 0) sum = 0;
		if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
		u = neg ? ONE_Q30 - longint'(unsigned'(sum)) : ONE_Q30 + longint'(unsigned'(sum));
		return 8'((u * 64'd255) >> 31);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t r;
		for (int unsigned p = 0; p < TABLE_LEN; p++) begin
			r[p] = sine_entry(p);
		end
		return r;
	endfunction

endpackage

[rtl/distance_beep_tone_generator.sv]
// Distance beep tone generator: one request in, one result out.
// Path: an accepted request is held in the item queue (dbt_fifo) until the back stage
// takes it, and the back stage registers its result before offering it on rsp.
// Throughput: one request per cycle unless rsp_ready holds the flow; the back stage carries out
// a whole tick each item, and the sine ROM read is registered together with the result.
// Reset: queues empty, sequencer and player idle, DAC level 0; ready straight after reset.
module distance_beep_tone_generator import dbt_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	item_t f_item;
	item_t q_item;
	logic  q_valid;
	logic  q_ready;

	// Classify requests
	dbt_front u_front (
		.req  (req),
		.item (f_item)
	);

	// Decouple front and back
	dbt_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (req_valid),
		.push_ready (req_ready),
		.push_item  (f_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	// Carry out items and deliver results
	dbt_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item       (q_item),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

[rtl/dbt_front.sv]
// Front part: classifies a request into a queue item.
// Depends on dbt_pkg (req_t, item_t, command and pattern codes).
module dbt_front import dbt_pkg::*; (
	input  req_t  req,
	output item_t item
);

	logic [CODE_W-1:0] code;
	logic [16:0]       rem;

	// Pick the pattern from the flags, highest priority first
	always_comb begin
		if (req.very_close)     code = PAT_VERY_CLOSE;
		else if (req.mid_close) code = PAT_MID_CLOSE;
		else if (req.far_flag)  code = PAT_FAR;
		else if (req.very_far)  code = PAT_VERY_FAR;
		else                    code = PAT_NONE;
	end

	// Reduce the frequency modulo the sample rate by restoring subtraction
	always_comb begin
		rem = {1'b0, req.tone_freq};
		for (int k = 6; k >= 0; k--) begin
			if (rem >= 17'(RATE_HZ << k)) rem = rem - 17'(RATE_HZ << k);
		end
	end

	// Build the item
	always_comb begin
		item.kind    = req.cmd;
		item.code    = code;
		item.tone.ps = rem[PHASE_W-1:0];
		item.tone.ms = req.tone_ms;
	end

endmodule

[rtl/dbt_fifo.sv]
// Short queue of classified items between the front and the back.
// Depends on dbt_pkg (item_t, XQ_DEPTH).
module dbt_fifo import dbt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	localparam int unsigned PW = (XQ_DEPTH > 1) ? $clog2(XQ_DEPTH) : 1;
	localparam int unsigned CW = $clog2(XQ_DEPTH + 1);

	item_t         mem_q [XQ_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = cnt_q != CW'(XQ_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store pushed items
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_item;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(XQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == PW'(XQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

[rtl/dbt_back.sv]
// Back part: event and tone queues, pattern sequencer, tone player, sine ROM, result stage.
// Depends on dbt_pkg (item_t, rsp_t, pattern tables, sine ROM builder).
module dbt_back import dbt_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	output logic  rsp_valid,
	input  logic  rsp_ready,
	output rsp_t  rsp
);

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// Queue storage
	logic [CODE_W-1:0] ev_mem_q [QUEUE_DEPTH];
	tone_t             t_mem_q  [QUEUE_DEPTH];
	logic [PW-1:0]     ev_wr_q, ev_rd_q, t_wr_q, t_rd_q;
	logic [CW-1:0]     ev_cnt_q, t_cnt_q;

	// Sequencer and player state
	logic [GAP_W-1:0]   gap_q;
	logic [REP_W-1:0]   rep_q;
	logic [CODE_W-1:0]  code_q;
	logic [15:0]        smp_q;
	logic [PHASE_W-1:0] ps_q;
	logic [PHASE_W-1:0] sp_q;
	logic [7:0]         dac_level_q;

	// Result stage
	logic       valid_s2;
	logic       tick_s2;
	logic       play_s2;
	logic       accepted_s2;
	logic       playing_s2;
	logic [7:0] rom_s2;

	// Next-state logic
	logic               adv;
	logic [GAP_W-1:0]   g1, n_gap;
	logic [REP_W-1:0]   rep1, n_rep;
	logic [CODE_W-1:0]  code1, n_code;
	logic               ev_push, ev_pop;
	logic               t_push, t_pop;
	tone_t              t_push_e, head;
	logic [CW-1:0]      t_mid;
	logic [15:0]        smp1, n_smp;
	logic [PHASE_W-1:0] ps1, n_ps, sp1, n_sp, rd_idx;
	logic [PHASE_W:0]   sum;
	logic               tick, play, accepted, playing;

	assign item_ready = !valid_s2 || rsp_ready;
	assign adv        = item_valid && item_ready;

	// Carry out one item: sequencer then player on a tick, a queue push on an event or tone
	always_comb begin
		g1       = gap_q;
		rep1     = rep_q;
		code1    = code_q;
		n_gap    = gap_q;
		n_rep    = rep_q;
		n_code   = code_q;
		ev_push  = 1'b0;
		ev_pop   = 1'b0;
		t_push   = 1'b0;
		t_pop    = 1'b0;
		t_push_e = item.tone;
		head     = t_mem_q[t_rd_q];
		t_mid    = t_cnt_q;
		smp1     = smp_q;
		ps1      = ps_q;
		sp1      = sp_q;
		n_smp    = smp_q;
		n_ps     = ps_q;
		n_sp     = sp_q;
		sum      = '0;
		rd_idx   = sp_q;
		tick     = 1'b0;
		play     = 1'b0;
		accepted = 1'b0;
		playing  = smp_q != '0;
		case (item.kind)
			CMD_TICK: begin
				tick = 1'b1;
				// count the gap down, fetch the next pattern when idle
				if (gap_q != '0) g1 = gap_q - 1'b1;
				if (g1 == '0 && rep_q == '0) begin
					if (ev_cnt_q != '0) begin
						ev_pop = 1'b1;
						code1  = ev_mem_q[ev_rd_q];
						rep1   = pat_reps(ev_mem_q[ev_rd_q]);
					end else begin
						code1 = PAT_NONE;
					end
				end
				n_gap  = g1;
				n_rep  = rep1;
				n_code = code1;
				// post one beep and load the gap
				if (g1 == '0 && rep1 != '0) begin
					t_push      = t_cnt_q < CW'(QUEUE_DEPTH);
					t_push_e.ps = pat_freq(code1);
					t_push_e.ms = pat_ms(code1);
					n_rep       = rep1 - 1'b1;
					n_gap       = pat_gap(code1);
				end
				// load the next tone when the player is idle
				t_mid = t_cnt_q + CW'(t_push);
				if (smp_q == '0 && t_mid != '0) begin
					t_pop = 1'b1;
					head  = (t_cnt_q == '0) ? t_push_e : t_mem_q[t_rd_q];
					smp1  = head.ms;
					ps1   = head.ps;
					sp1   = '0;
				end
				n_ps   = ps1;
				n_sp   = sp1;
				n_smp  = smp1;
				rd_idx = sp1;
				// emit one sample and step the phase
				if (smp1 != '0) begin
					play  = 1'b1;
					sum   = {1'b0, sp1} + {1'b0, ps1};
					n_sp  = (sum >= (PHASE_W + 1)'(RATE_HZ)) ?
						PHASE_W'(sum - (PHASE_W + 1)'(RATE_HZ)) : sum[PHASE_W-1:0];
					n_smp = smp1 - 1'b1;
				end
				playing = play;
			end
			CMD_EVENT: begin
				if (ev_cnt_q < CW'(QUEUE_DEPTH)) begin
					ev_push  = 1'b1;
					accepted = 1'b1;
				end
			end
			CMD_TONE: begin
				if (t_cnt_q < CW'(QUEUE_DEPTH)) begin
					t_push   = 1'b1;
					accepted = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Write queue entries
	always_ff @(posedge clk) begin
		if (adv && ev_push) ev_mem_q[ev_wr_q] <= item.code;
		if (adv && t_push)  t_mem_q[t_wr_q]   <= t_push_e;
	end

	// Read the sine ROM alongside the result stage
	always_ff @(posedge clk) begin
		if (adv) rom_s2 <= SINE_ROM[rd_idx];
	end

	// Update queue pointers, sequencer and player state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_wr_q  <= '0;
			ev_rd_q  <= '0;
			ev_cnt_q <= '0;
			t_wr_q   <= '0;
			t_rd_q   <= '0;
			t_cnt_q  <= '0;
			gap_q    <= '0;
			rep_q    <= '0;
			code_q   <= PAT_NONE;
			smp_q    <= '0;
			ps_q     <= '0;
			sp_q     <= '0;
		end else if (adv) begin
			if (ev_push) ev_wr_q <= (ev_wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : ev_wr_q + 1'b1;
			if (ev_pop)  ev_rd_q <= (ev_rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : ev_rd_q + 1'b1;
			if (t_push)  t_wr_q  <= (t_wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : t_wr_q + 1'b1;
			if (t_pop)   t_rd_q  <= (t_rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : t_rd_q + 1'b1;
			ev_cnt_q <= ev_cnt_q + CW'(ev_push) - CW'(ev_pop);
			t_cnt_q  <= t_cnt_q + CW'(t_push) - CW'(t_pop);
			gap_q    <= n_gap;
			rep_q    <= n_rep;
			code_q   <= n_code;
			smp_q    <= n_smp;
			ps_q     <= n_ps;
			sp_q     <= n_sp;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			dac_level_q <= '0;
		end else begin
			if (rsp_valid && rsp_ready) dac_level_q <= rsp.dac_value;
			if (adv)            valid_s2 <= 1'b1;
			else if (rsp_ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tick_s2     <= tick;
			play_s2     <= play;
			accepted_s2 <= accepted;
			playing_s2  <= playing;
		end
	end

	// Drive the result: sample on a playing tick, zero on an idle tick, else hold level
	assign rsp_valid = valid_s2;
	always_comb begin
		if (play_s2)      rsp.dac_value = rom_s2;
		else if (tick_s2) rsp.dac_value = '0;
		else              rsp.dac_value = dac_level_q;
		rsp.accepted = accepted_s2;
		rsp.playing  = playing_s2;
	end

endmodule
